@@ rtl/crosspoint_route_matrix_loader_macros.svh @@
// ============================================================================
// Crosspoint route matrix loader assertion macros
// Concurrent assertion wrappers clocked on clk_i. They are empty in synthesis.
// ============================================================================
`ifndef CROSSPOINT_ROUTE_MATRIX_LOADER_MACROS_SVH
`define CROSSPOINT_ROUTE_MATRIX_LOADER_MACROS_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define CRPML_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Checked on every rising clock edge, reset included.
`define CRPML_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define CRPML_ASSERT(lbl, prop, msg)
`define CRPML_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/crpml_pkg.sv @@
// ============================================================================
// Crosspoint route matrix loader package
// Word types, command codes and queue sizing shared by the loader modules.
// ============================================================================
package crpml_pkg;

  // Port fields are fixed at five bits.
  localparam int unsigned PORT_W = 5;

  // Command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Function codes of an input word.
  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_QUERY = 3'd1,
    FUNC_CLEAR = 3'd2,
    FUNC_LOAD  = 3'd3,
    FUNC_START = 3'd4,
    FUNC_FLUSH = 3'd5,
    FUNC_TICK  = 3'd6,
    FUNC_NONE  = 3'd7
  } func_e;

  // Classified operations handed to the back.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_QUERY,
    OP_CLEAR,
    OP_LOAD,
    OP_START,
    OP_FLUSH,
    OP_TICK
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } back_state_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [PORT_W-1:0] x_port;
    logic [PORT_W-1:0] y_port;
    logic              route_on;
    logic              map_axis;
    logic [PORT_W-1:0] map_index;
    logic [PORT_W-1:0] map_value;
  } in_word_t;

  typedef struct packed {
    logic routed;
    logic start_ok;
    logic map_error;
    logic serial_data;
    logic shift_clock;
    logic latch_pulse;
    logic busy_res;
  } out_word_t;

  typedef struct packed {
    op_e               op;
    logic [PORT_W-1:0] x_port;
    logic [PORT_W-1:0] y_port;
    logic              route_on;
    logic              map_axis;
    logic [PORT_W-1:0] map_index;
    logic [PORT_W-1:0] map_value;
    logic              value_ok;
  } cmd_t;

endpackage

@@ rtl/crosspoint_route_matrix_loader.sv @@
// ============================================================================
// Crosspoint route matrix loader
// Words pass the front register, the queue and the back's result register;
// a route write, query or active tick first waits on the matrix memory read.
// Throughput: one word per cycle unless results stall or a read is pending.
// Reset: asynchronous; clears the matrix rows, maps to identity, flags idle.
// ============================================================================
`include "crosspoint_route_matrix_loader_macros.svh"

module crosspoint_route_matrix_loader #(
  parameter int unsigned MATRIX_PORTS   = 32,
  parameter int unsigned QUADRANT_PORTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  crpml_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output crpml_pkg::out_word_t out_word_o
);

  // The front registers one classified command. Routes with a logical port
  // beyond the matrix and map loads with an index beyond it are turned into
  // no-ops there, so the back never indexes past its stores.
  logic            fe_valid, q_ready;
  crpml_pkg::cmd_t fe_cmd;

  // The queue lets the front keep taking words while the back waits on a
  // memory read or on a full result register.
  logic            q_valid, q_pop;
  crpml_pkg::cmd_t q_cmd;

  crpml_front #(
    .MATRIX_PORTS(MATRIX_PORTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cmd_valid_o(fe_valid),
    .cmd_ready_i(q_ready),
    .cmd_o      (fe_cmd)
  );

  crpml_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fe_valid),
    .push_ready_o(q_ready),
    .push_cmd_i  (fe_cmd),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_cmd_o   (q_cmd)
  );

  // The back owns all architectural state. Clear-all drops all row valid
  // bits together; a row that is not valid reads as all zeros, so the
  // matrix memory itself needs no clearing pass. A route write is a
  // read-modify-write of one row, written back in the read state. During
  // a flush each tick reads the live row at the current quadrant position,
  // so commands issued between ticks are seen by later bits.
  crpml_back #(
    .MATRIX_PORTS  (MATRIX_PORTS),
    .QUADRANT_PORTS(QUADRANT_PORTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_ready_o(q_pop),
    .cmd_i      (q_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // Coming out of reset nothing is owed and the input is open.
  `CRPML_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o && in_ready_o,
    "result pending or input blocked after reset")
  // A result word that waits for the receiver holds still.
  `CRPML_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o),
    "result word changed before it was accepted")
  // Start can only succeed when no map error has been seen.
  `CRPML_ASSERT(a_start_clean,
    out_valid_o |-> !(out_word_o.start_ok && out_word_o.map_error),
    "start ok with map error")
  // The latch pulse comes with the final shift clock and ends the sequence.
  `CRPML_ASSERT(a_latch_ends,
    out_valid_o && out_word_o.latch_pulse |-> out_word_o.shift_clock && !out_word_o.busy_res,
    "latch pulse outside final tick")
  // Serial data is only driven on a clocked tick.
  `CRPML_ASSERT(a_data_clocked,
    out_valid_o && out_word_o.serial_data |-> out_word_o.shift_clock,
    "serial data without shift clock")

endmodule

@@ rtl/crpml_front.sv @@
// ============================================================================
// Crosspoint route matrix loader front
// Accepts input words, checks port ranges and registers a classified command.
// ============================================================================
module crpml_front #(
  parameter int unsigned MATRIX_PORTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crpml_pkg::in_word_t in_word_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output crpml_pkg::cmd_t     cmd_o
);

  logic            valid_q, valid_d;
  crpml_pkg::cmd_t cmd_q, cls;
  logic            ports_ok, index_ok, take;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // Out-of-range routes and map indexes have no effect, so they become no-ops here.
  always_comb begin
    ports_ok = (int'(in_word_i.x_port) < MATRIX_PORTS) &&
               (int'(in_word_i.y_port) < MATRIX_PORTS);
    index_ok = int'(in_word_i.map_index) < MATRIX_PORTS;
    cls.x_port    = in_word_i.x_port;
    cls.y_port    = in_word_i.y_port;
    cls.route_on  = in_word_i.route_on;
    cls.map_axis  = in_word_i.map_axis;
    cls.map_index = in_word_i.map_index;
    cls.map_value = in_word_i.map_value;
    cls.value_ok  = int'(in_word_i.map_value) < MATRIX_PORTS;
    unique case (crpml_pkg::func_e'(in_word_i.func))
      crpml_pkg::FUNC_WRITE: cls.op = ports_ok ? crpml_pkg::OP_WRITE : crpml_pkg::OP_NONE;
      crpml_pkg::FUNC_QUERY: cls.op = ports_ok ? crpml_pkg::OP_QUERY : crpml_pkg::OP_NONE;
      crpml_pkg::FUNC_CLEAR: cls.op = crpml_pkg::OP_CLEAR;
      crpml_pkg::FUNC_LOAD:  cls.op = index_ok ? crpml_pkg::OP_LOAD : crpml_pkg::OP_NONE;
      crpml_pkg::FUNC_START: cls.op = crpml_pkg::OP_START;
      crpml_pkg::FUNC_FLUSH: cls.op = crpml_pkg::OP_FLUSH;
      crpml_pkg::FUNC_TICK:  cls.op = crpml_pkg::OP_TICK;
      default:               cls.op = crpml_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cls;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

@@ rtl/crpml_queue.sv @@
// ============================================================================
// Crosspoint route matrix loader command queue
// Short first-in first-out buffer that decouples the front from the back.
// ============================================================================
module crpml_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  crpml_pkg::cmd_t push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output crpml_pkg::cmd_t pop_cmd_o
);

  crpml_pkg::cmd_t                       buf_q [crpml_pkg::QUEUE_DEPTH];
  logic [crpml_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [crpml_pkg::QUEUE_CNT_W-1:0]     count_q;
  logic                                  do_push, do_pop;

  assign push_ready_o = count_q != crpml_pkg::QUEUE_CNT_W'(crpml_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_cmd_o    = buf_q[rd_ptr_q];

  function automatic logic [crpml_pkg::QUEUE_PTR_W-1:0] next_ptr(
    input logic [crpml_pkg::QUEUE_PTR_W-1:0] ptr
  );
    if (ptr == crpml_pkg::QUEUE_PTR_W'(crpml_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/crpml_back.sv @@
// ============================================================================
// Crosspoint route matrix loader back
// Executes commands against the port maps and the route matrix memory, runs
// the quadrant shift sequence and holds the result word register.
// ============================================================================
module crpml_back #(
  parameter int unsigned MATRIX_PORTS   = 32,
  parameter int unsigned QUADRANT_PORTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  crpml_pkg::cmd_t      cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output crpml_pkg::out_word_t out_word_o
);

  localparam int unsigned IDX_W = $clog2(MATRIX_PORTS);
  localparam int unsigned QB_W  = $clog2(QUADRANT_PORTS);
  localparam int unsigned RC_W  = $clog2(2 * QUADRANT_PORTS);
  localparam logic [QB_W-1:0] QUAD_LAST = QB_W'(QUADRANT_PORTS - 1);
  localparam logic [RC_W-1:0] EDGE_HI   = RC_W'(2 * QUADRANT_PORTS - 1);
  localparam logic [RC_W-1:0] EDGE_LO   = RC_W'(QUADRANT_PORTS - 1);

  crpml_pkg::back_state_e state_q, state_d;

  // Port maps and their used masks.
  logic [IDX_W-1:0]        x_map_q [MATRIX_PORTS];
  logic [IDX_W-1:0]        y_map_q [MATRIX_PORTS];
  logic [MATRIX_PORTS-1:0] x_used_q, y_used_q;
  logic                    err_q, begun_q;

  // Route matrix: one row per physical y, physical x as the bit.
  logic [MATRIX_PORTS-1:0] mem_q [MATRIX_PORTS];
  logic [MATRIX_PORTS-1:0] row_valid_q;
  logic [MATRIX_PORTS-1:0] rd_data_q, wr_data;
  logic                    rd_rv_q;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;

  // Shift sequencer.
  logic            active_q;
  logic [1:0]      quad_q;
  logic [QB_W-1:0] r_q, c_q;
  logic [RC_W-1:0] sh_row, sh_col;
  logic            sh_ok, sh_last;

  // Operation waiting on the memory read.
  crpml_pkg::op_e   pend_op_q;
  logic [IDX_W-1:0] pend_row_q, pend_col_q, pend_row_d, pend_col_d;
  logic             pend_on_q, pend_ok_q, pend_ok_d, pend_last_q;

  logic                 out_valid_q;
  crpml_pkg::out_word_t out_word_q, res;
  logic                 res_valid, out_free, take;
  logic                 load_wr, load_err, clr_rows, begin_set, flush_go, tick_go;
  logic [IDX_W-1:0]     map_row, map_col, load_idx, load_val;
  logic                 load_used, hit;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == crpml_pkg::ST_IDLE) && out_free;
  assign take        = cmd_valid_i && cmd_ready_o;

  assign map_row   = y_map_q[cmd_i.y_port[IDX_W-1:0]];
  assign map_col   = x_map_q[cmd_i.x_port[IDX_W-1:0]];
  assign load_idx  = cmd_i.map_index[IDX_W-1:0];
  assign load_val  = cmd_i.map_value[IDX_W-1:0];
  assign load_used = cmd_i.map_axis ? y_used_q[load_val] : x_used_q[load_val];

  // Quadrants go high rows before low rows, and within a row band high columns first.
  assign sh_row  = ((quad_q < 2'd2) ? EDGE_HI : EDGE_LO) - RC_W'(r_q);
  assign sh_col  = ((quad_q[0] == 1'b0) ? EDGE_HI : EDGE_LO) - RC_W'(c_q);
  assign sh_ok   = (int'(sh_row) < MATRIX_PORTS) && (int'(sh_col) < MATRIX_PORTS);
  assign sh_last = (quad_q == 2'd3) && (r_q == QUAD_LAST) && (c_q == QUAD_LAST);

  assign hit = rd_rv_q && rd_data_q[pend_col_q] && pend_ok_q;

  always_comb begin
    wr_data             = rd_rv_q ? rd_data_q : '0;
    wr_data[pend_col_q] = pend_on_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crpml_pkg::ST_IDLE: begin
        if (take && ((cmd_i.op == crpml_pkg::OP_WRITE) ||
                     (cmd_i.op == crpml_pkg::OP_QUERY) ||
                     (cmd_i.op == crpml_pkg::OP_TICK && active_q))) begin
          state_d = crpml_pkg::ST_READ;
        end
      end
      crpml_pkg::ST_READ: state_d = crpml_pkg::ST_IDLE;
      default:            state_d = crpml_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res        = '0;
    res_valid  = 1'b0;
    load_wr    = 1'b0;
    load_err   = 1'b0;
    clr_rows   = 1'b0;
    begin_set  = 1'b0;
    flush_go   = 1'b0;
    tick_go    = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = map_row;
    pend_row_d = map_row;
    pend_col_d = map_col;
    pend_ok_d  = 1'b1;
    unique case (state_q)
      crpml_pkg::ST_IDLE: begin
        if (take) begin
          res_valid = 1'b1;
          unique case (cmd_i.op) inside
            crpml_pkg::OP_WRITE, crpml_pkg::OP_QUERY: res_valid = 1'b0;
            crpml_pkg::OP_CLEAR: clr_rows = 1'b1;
            crpml_pkg::OP_LOAD: begin
              if (!cmd_i.value_ok || load_used) begin
                load_err = 1'b1;
              end else begin
                load_wr = 1'b1;
              end
            end
            crpml_pkg::OP_START: begin
              res.start_ok = !err_q;
              begin_set    = !err_q;
            end
            crpml_pkg::OP_FLUSH: flush_go = begun_q && !active_q;
            crpml_pkg::OP_TICK: begin
              if (active_q) begin
                res_valid  = 1'b0;
                tick_go    = 1'b1;
                rd_addr    = IDX_W'(sh_row);
                pend_row_d = IDX_W'(sh_row);
                pend_col_d = IDX_W'(sh_col);
                pend_ok_d  = sh_ok;
              end
            end
            default: ;
          endcase
          res.map_error = err_q || load_err;
          res.busy_res  = active_q || flush_go;
        end
      end
      crpml_pkg::ST_READ: begin
        res_valid     = 1'b1;
        res.map_error = err_q;
        res.busy_res  = active_q;
        unique case (pend_op_q)
          crpml_pkg::OP_WRITE: mem_we = 1'b1;
          crpml_pkg::OP_QUERY: res.routed = hit;
          crpml_pkg::OP_TICK: begin
            res.serial_data = hit;
            res.shift_clock = 1'b1;
            res.latch_pulse = pend_last_q;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crpml_pkg::ST_IDLE;
      for (int i = 0; i < MATRIX_PORTS; i++) begin
        x_map_q[i] <= IDX_W'(i);
        y_map_q[i] <= IDX_W'(i);
      end
      x_used_q    <= '0;
      y_used_q    <= '0;
      err_q       <= 1'b0;
      begun_q     <= 1'b0;
      row_valid_q <= '0;
      rd_rv_q     <= 1'b0;
      active_q    <= 1'b0;
      quad_q      <= '0;
      r_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_wr) begin
        if (cmd_i.map_axis) begin
          y_map_q[load_idx]  <= load_val;
          y_used_q[load_val] <= 1'b1;
        end else begin
          x_map_q[load_idx]  <= load_val;
          x_used_q[load_val] <= 1'b1;
        end
      end
      if (load_err) begin
        err_q <= 1'b1;
      end
      if (begin_set) begin
        begun_q <= 1'b1;
      end
      if (clr_rows) begin
        row_valid_q <= '0;
      end else if (mem_we) begin
        row_valid_q[pend_row_q] <= 1'b1;
      end
      rd_rv_q <= row_valid_q[rd_addr];
      if (flush_go) begin
        active_q <= 1'b1;
        quad_q   <= '0;
        r_q      <= '0;
        c_q      <= '0;
      end else if (tick_go) begin
        // The counters wrap back to zero on the last bit.
        if (sh_last) begin
          active_q <= 1'b0;
        end
        if (c_q == QUAD_LAST) begin
          c_q <= '0;
          if (r_q == QUAD_LAST) begin
            r_q    <= '0;
            quad_q <= quad_q + 2'd1;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[pend_row_q] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
    if (take) begin
      pend_op_q   <= cmd_i.op;
      pend_row_q  <= pend_row_d;
      pend_col_q  <= pend_col_d;
      pend_on_q   <= cmd_i.route_on;
      pend_ok_q   <= pend_ok_d;
      pend_last_q <= sh_last;
    end
    if (res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ tb/sv/tb_crosspoint_route_matrix_loader.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Crosspoint route matrix loader testbench
// Drives command words through the valid/ready input channel, mirrors the
// route matrix, port maps and serial shift in a scoreboard, and checks every
// result word field by field while both channels idle and stall at random.
// ============================================================================
module tb_crosspoint_route_matrix_loader;

  // Sizes of the block as built, and run timing.
  localparam int unsigned MATRIX      = 32;
  localparam int unsigned QUAD        = 16;
  localparam int unsigned SHIFT_BITS  = 4 * QUAD * QUAD;
  localparam int unsigned RANDOM_MIN  = 1130;
  localparam int unsigned RANDOM_CAP  = 5000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned DRAIN       = 20;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // The scoreboard keeps its own copy of everything the block stores: the
  // route rows (indexed by physical y, physical x as the bit), both port maps
  // with their used masks, the sticky error and begun flags and the shift
  // position. Every accepted input word produces exactly one result word, so
  // the expected results form a simple in-order queue.
  class loader_mirror;
    logic [MATRIX-1:0]    route_rows [MATRIX];
    logic [4:0]           x_map [MATRIX];
    logic [4:0]           y_map [MATRIX];
    logic [MATRIX-1:0]    x_used;
    logic [MATRIX-1:0]    y_used;
    bit                   err_flag;
    bit                   begun;
    int unsigned          shift_pos;
    crpml_pkg::out_word_t expected_words [$];
    int unsigned          words_in;
    int unsigned          words_out;
    int unsigned          mismatches;
    int unsigned          latches;
    int unsigned          active_ticks;
    int unsigned          query_hits;
    int unsigned          load_errors;

    function new();
      for (int i = 0; i < MATRIX; i++) begin
        route_rows[i] = '0;
        x_map[i]      = 5'(i);
        y_map[i]      = 5'(i);
      end
      x_used    = '0;
      y_used    = '0;
      err_flag  = 1'b0;
      begun     = 1'b0;
      shift_pos = 0;
    endfunction

    function bit shifting();
      return shift_pos != 0;
    endfunction

    // Applies one accepted word to the mirrored state and queues the result
    // the block owes for it.
    function void note_word(crpml_pkg::in_word_t w);
      crpml_pkg::out_word_t res;
      int unsigned          k;
      int unsigned          quad;
      int unsigned          quad_off;
      int unsigned          row;
      int unsigned          col;
      logic [MATRIX-1:0]    used;
      res = '0;
      case (crpml_pkg::func_e'(w.func))
        crpml_pkg::FUNC_WRITE: begin
          row = int'(y_map[w.y_port]);
          col = int'(x_map[w.x_port]);
          route_rows[row][col] = w.route_on;
        end
        crpml_pkg::FUNC_QUERY: begin
          res.routed = route_rows[y_map[w.y_port]][x_map[w.x_port]];
          if (res.routed) query_hits++;
        end
        crpml_pkg::FUNC_CLEAR: begin
          foreach (route_rows[i]) route_rows[i] = '0;
        end
        crpml_pkg::FUNC_LOAD: begin
          // A physical port may be handed out once per axis. Reloading an
          // index leaves its old value marked as taken.
          used = w.map_axis ? y_used : x_used;
          if (used[w.map_value]) begin
            err_flag = 1'b1;
            load_errors++;
          end else begin
            used[w.map_value] = 1'b1;
            if (w.map_axis) begin
              y_map[w.map_index] = w.map_value;
              y_used = used;
            end else begin
              x_map[w.map_index] = w.map_value;
              x_used = used;
            end
          end
        end
        crpml_pkg::FUNC_START: begin
          if (!err_flag) begin
            res.start_ok = 1'b1;
            begun = 1'b1;
          end
        end
        crpml_pkg::FUNC_FLUSH: begin
          if (begun && shift_pos == 0) shift_pos = 1;
        end
        crpml_pkg::FUNC_TICK: begin
          if (shift_pos != 0) begin
            // Quadrants go high/high, high/low, low/high, low/low (rows then
            // columns), each walked with rows and columns descending.
            k        = shift_pos - 1;
            quad     = k / (QUAD * QUAD);
            quad_off = k % (QUAD * QUAD);
            row      = ((quad < 2) ? 2 * QUAD - 1 : QUAD - 1) - quad_off / QUAD;
            col      = ((quad % 2 == 0) ? 2 * QUAD - 1 : QUAD - 1) - quad_off % QUAD;
            res.serial_data = route_rows[row][col];
            res.shift_clock = 1'b1;
            active_ticks++;
            if (k + 1 >= SHIFT_BITS) begin
              res.latch_pulse = 1'b1;
              shift_pos = 0;
              latches++;
            end else begin
              shift_pos = k + 2;
            end
          end
        end
        default: ;
      endcase
      res.map_error = err_flag;
      res.busy_res  = (shift_pos != 0);
      expected_words.push_back(res);
      words_in++;
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_word(crpml_pkg::out_word_t got);
      crpml_pkg::out_word_t want;
      string                names [7] = '{"routed", "start_ok", "map_error", "serial_data",
                                          "shift_clock", "latch_pulse", "busy_res"};
      if (expected_words.size() == 0) begin
        $display("%0t: result %b arrived with no command outstanding", $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      words_out++;
      for (int i = 0; i < 7; i++) begin
        if (got[6-i] !== want[6-i]) begin
          $display("%0t: mismatch on %s of result %0d, expected %b, got %b",
                   $time, names[i], words_out, want[6-i], got[6-i]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  crpml_pkg::in_word_t  in_word_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  crpml_pkg::out_word_t out_word_o;

  loader_mirror mirror = new();
  int unsigned  send_burst;
  int unsigned  cycles;

  crosspoint_route_matrix_loader uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // 8 ns clock, starting low.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog. A healthy run finishes far below this count, so reaching it
  // means the block has hung or dropped a word.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed",
               $time, cycles, mirror.expected_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Both channels are observed at the rising edge. Inputs only change on the
  // falling edge, so the values seen here are the ones the block accepts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) mirror.note_word(in_word_i);
      if (out_valid_o && out_ready_i) mirror.check_word(out_word_o);
    end
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic crpml_pkg::in_word_t make_word(crpml_pkg::func_e f, int unsigned x,
                                                    int unsigned y, bit on, bit axis,
                                                    int unsigned idx, int unsigned val);
    crpml_pkg::in_word_t w;
    w.func      = f;
    w.x_port    = 5'(x);
    w.y_port    = 5'(y);
    w.route_on  = on;
    w.map_axis  = axis;
    w.map_index = 5'(idx);
    w.map_value = 5'(val);
    return w;
  endfunction

  // Random command. While a shift runs, ticks dominate so the 1024-bit
  // stream completes, with route traffic mixed in to hit live matrix reads.
  // While idle, flush is favored so a new shift starts soon.
  function automatic crpml_pkg::in_word_t random_word(bit busy);
    crpml_pkg::in_word_t w;
    int unsigned         roll;
    bit                  hot;
    roll = $urandom_range(0, 99);
    if (busy) begin
      if (roll < 90)      w.func = crpml_pkg::FUNC_TICK;
      else if (roll < 93) w.func = crpml_pkg::FUNC_WRITE;
      else if (roll < 95) w.func = crpml_pkg::FUNC_QUERY;
      else if (roll < 96) w.func = crpml_pkg::FUNC_CLEAR;
      else if (roll < 97) w.func = crpml_pkg::FUNC_LOAD;
      else if (roll < 98) w.func = crpml_pkg::FUNC_FLUSH;
      else if (roll < 99) w.func = crpml_pkg::FUNC_START;
      else                w.func = crpml_pkg::FUNC_NONE;
    end else begin
      if (roll < 40)      w.func = crpml_pkg::FUNC_FLUSH;
      else if (roll < 65) w.func = crpml_pkg::FUNC_WRITE;
      else if (roll < 80) w.func = crpml_pkg::FUNC_QUERY;
      else if (roll < 85) w.func = crpml_pkg::FUNC_TICK;
      else if (roll < 90) w.func = crpml_pkg::FUNC_LOAD;
      else if (roll < 95) w.func = crpml_pkg::FUNC_START;
      else if (roll < 97) w.func = crpml_pkg::FUNC_CLEAR;
      else                w.func = crpml_pkg::FUNC_NONE;
    end
    // Half of the route traffic stays in a small corner so that queries
    // find routes that were written.
    hot = 1'($urandom_range(0, 1));
    w.x_port    = hot ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    w.y_port    = hot ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    w.route_on  = ($urandom_range(0, 9) < 7);
    w.map_axis  = 1'($urandom_range(0, 1));
    w.map_index = 5'($urandom_range(0, 31));
    w.map_value = 5'($urandom_range(0, 31));
    return w;
  endfunction

  // Offers one word and returns at the falling edge after it was taken.
  // Valid is only lowered when a gap is inserted, so it never drops and
  // rises within one time step.
  task automatic send_word(input crpml_pkg::in_word_t w);
    int unsigned gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) send_burst = $urandom_range(30, 80);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Result side. Ready toggles with random stalls and bursts. Once, after a
  // few hundred results, it is held low long enough for the internal queue
  // to fill and push back on the input while the sender keeps offering.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned burst_left;
    int unsigned roll;
    bit          held;
    out_ready_i = 1'b0;
    stall_left  = 0;
    burst_left  = 0;
    held        = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && mirror.words_out >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
        burst_left = 0;
      end
      if (stall_left == 0 && burst_left > 0) begin
        burst_left--;
      end else if (stall_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) burst_left = $urandom_range(40, 100);
        else if (roll < 20) stall_left = pick_gap();
      end
      out_ready_i <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : stimulus
    int unsigned n;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    rst_ni     = 1'b0;
    send_burst = 0;
    cycles     = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening. Nothing is begun yet, so the idle tick and the early
    // flush must both do nothing.
    send_word(make_word(crpml_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_FLUSH, 31, 31, 1, 1, 31, 31));
    send_word(make_word(crpml_pkg::FUNC_NONE, 31, 31, 1, 1, 31, 31));
    send_word(make_word(crpml_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 0));
    // Corner routes through the identity maps, then queried and one removed.
    send_word(make_word(crpml_pkg::FUNC_WRITE, 0, 0, 1, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_WRITE, 31, 31, 1, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_WRITE, 31, 0, 1, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_QUERY, 31, 31, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_QUERY, 0, 31, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_WRITE, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 0));
    // Clear all must wipe the remaining corner routes.
    send_word(make_word(crpml_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_QUERY, 31, 31, 0, 0, 0, 0));
    // Map loads on both axes, including a reload of the same index with a
    // fresh value, which is legal.
    send_word(make_word(crpml_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 31));
    send_word(make_word(crpml_pkg::FUNC_LOAD, 0, 0, 0, 1, 31, 0));
    send_word(make_word(crpml_pkg::FUNC_LOAD, 0, 0, 0, 1, 31, 1));
    send_word(make_word(crpml_pkg::FUNC_WRITE, 0, 31, 1, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_WRITE, 15, 16, 1, 0, 0, 0));
    // Start with a clean error flag, then flush twice: the second one lands
    // while the shift is already running and is dropped.
    send_word(make_word(crpml_pkg::FUNC_START, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_FLUSH, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_FLUSH, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_QUERY, 0, 31, 0, 0, 0, 0));

    // Random part. It runs on past its nominal length until at least one
    // full shift has ended with a latch pulse.
    n = 0;
    while ((n < RANDOM_MIN || mirror.latches == 0) && n < RANDOM_CAP) begin
      send_word(random_word(mirror.shifting()));
      n++;
    end

    // Closing: the second identical load is a duplicate whatever happened
    // before, so the following start must be refused.
    send_word(make_word(crpml_pkg::FUNC_LOAD, 0, 0, 0, 0, 2, 9));
    send_word(make_word(crpml_pkg::FUNC_LOAD, 0, 0, 0, 0, 2, 9));
    send_word(make_word(crpml_pkg::FUNC_START, 0, 0, 0, 0, 0, 0));
    send_word(make_word(crpml_pkg::FUNC_QUERY, 3, 3, 0, 0, 0, 0));
    in_valid_i <= 1'b0;

    // Wait for every owed result, then keep watching to catch strays.
    while (mirror.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Run covered %0d command words and %0d result words in %0d cycles.",
             mirror.words_in, mirror.words_out, cycles);
    $display("Active ticks %0d, completed shifts %0d, query hits %0d, map errors %0d.",
             mirror.active_ticks, mirror.latches, mirror.query_hits, mirror.load_errors);
    if (mirror.mismatches == 0 && mirror.expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
